// ===== src/scpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// scpwm_pkg
// shared types, register map and reset constants of the sixteen channel
// pwm register block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scpwm_pkg;

  // sizing
  localparam int CHANNELS   = 16;
  localparam int CYCLE_BITS = 12;
  localparam int BYTE_W     = 8;
  localparam int PWM_W      = 16;
  localparam int ACT_W      = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;
  localparam int CH_SPAN    = 4 * CHANNELS;

  // item kinds on in_tuser
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;

  // register map
  localparam logic [BYTE_W-1:0] ADDR_MODE1    = 8'h00;
  localparam logic [BYTE_W-1:0] ADDR_MODE2    = 8'h01;
  localparam logic [BYTE_W-1:0] CH_BASE       = 8'h06;
  localparam logic [BYTE_W-1:0] ALL_BASE      = 8'hFA;
  localparam logic [BYTE_W-1:0] ALL_LAST      = 8'hFD;
  localparam logic [BYTE_W-1:0] PRESCALE_ADDR = 8'hFE;

  // byte slots inside one channel
  localparam logic [1:0] SLOT_ON_L  = 2'd0;
  localparam logic [1:0] SLOT_ON_H  = 2'd1;
  localparam logic [1:0] SLOT_OFF_L = 2'd2;
  localparam logic [1:0] SLOT_OFF_H = 2'd3;

  // bit positions
  localparam int FORCE_BIT  = 4;
  localparam int SLEEP_BIT  = 4;
  localparam int INVERT_BIT = 4;

  // reset values and limits
  localparam logic [BYTE_W-1:0] MODE1_RST      = 8'h11;
  localparam logic [BYTE_W-1:0] MODE2_RST      = 8'h04;
  localparam logic [BYTE_W-1:0] PRESCALE_RST   = 8'd30;
  localparam logic [BYTE_W-1:0] PRESCALE_FLOOR = 8'd3;
  localparam logic [BYTE_W-1:0] OFF_H_RST      = 8'h10;

  typedef logic [BYTE_W-1:0]     byte_t;
  typedef logic [CYCLE_BITS-1:0] cyc_t;
  typedef logic [3:0][BYTE_W-1:0] chan_bytes_t;

  // byte write into one channel
  typedef struct packed {
    logic       en;
    logic [1:0] slot;
    byte_t      data;
  } scpwm_wr_t;

endpackage

`default_nettype wire

// ===== src/scpwm_chan.sv =====
// ----------------------------------------------------------------------------
// scpwm_chan
// one pwm channel: its four window bytes and the on/off window compare
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scpwm_chan (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire scpwm_pkg::scpwm_wr_t     wr,
  input  wire scpwm_pkg::cyc_t          cyc_nxt,
  input  wire logic                     invert_nxt,
  output scpwm_pkg::chan_bytes_t        bytes,
  output logic                          level_nxt
);
  import scpwm_pkg::*;

  chan_bytes_t bytes_r;
  chan_bytes_t bytes_nxt;
  cyc_t        on_val;
  cyc_t        off_val;
  logic        raw_lvl;

  // byte write
  always_comb begin
    bytes_nxt = bytes_r;
    if (wr.en) begin
      bytes_nxt[wr.slot] = wr.data;
    end
  end

  // off-high is the top slot; only its full-off bit is set at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r <= {OFF_H_RST, {(3*BYTE_W){1'b0}}};
    end else begin
      bytes_r <= bytes_nxt;
    end
  end

  assign bytes = bytes_r;

  // window compare on the updated bytes and count
  assign on_val  = cyc_t'({bytes_nxt[SLOT_ON_H][3:0], bytes_nxt[SLOT_ON_L]});
  assign off_val = cyc_t'({bytes_nxt[SLOT_OFF_H][3:0], bytes_nxt[SLOT_OFF_L]});

  always_comb begin
    if (bytes_nxt[SLOT_OFF_H][FORCE_BIT]) begin
      raw_lvl = 1'b0;
    end else if (bytes_nxt[SLOT_ON_H][FORCE_BIT]) begin
      raw_lvl = 1'b1;
    end else if (on_val < off_val) begin
      raw_lvl = (cyc_nxt >= on_val) && (cyc_nxt < off_val);
    end else if (on_val > off_val) begin
      raw_lvl = (cyc_nxt >= on_val) || (cyc_nxt < off_val);
    end else begin
      raw_lvl = 1'b0;
    end
  end

  assign level_nxt = raw_lvl ^ invert_nxt;

endmodule

`default_nettype wire

// ===== src/sixteen_channel_pwm_register_block.sv =====
// ----------------------------------------------------------------------------
// sixteen_channel_pwm_register_block
// register-mapped pwm generator: byte writes, byte reads and oscillator ticks
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one beat per operation. in_tuser is the kind (write, read, tick),
//           in_tdata carries the register address and the write byte.
//   out_* : one beat per input beat, in order: the read byte (zero for
//           anything but a read of a mapped register) and the sixteen
//           channel levels as they stand after that operation.
//   An input register, then the decode, state update and sixteen window
//   compares run in one pass into the result register.
//   Throughput is one beat per cycle unless the result stalls; ticks may arrive every cycle.
//   Reset (rst_n low, synchronous) puts the block to sleep with prescale 30,
//   all channels forced off, other window bytes and counters at zero.
//   When out_tready is low the result holds; one more beat is taken into the
//   input register, then in_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sixteen_channel_pwm_register_block (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [7:0] reg_addr, [15:8] write_data
  input  wire logic [scpwm_pkg::IN_DATA_W-1:0]     in_tdata,
  // [1:0] action
  input  wire logic [scpwm_pkg::ACT_W-1:0]         in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [7:0] read_data, [23:8] pwm_levels
  output logic [scpwm_pkg::OUT_DATA_W-1:0]         out_tdata
);
  import scpwm_pkg::*;

  // input register
  logic             s1_valid_r;
  logic [ACT_W-1:0] s1_act_r;
  byte_t            s1_addr_r;
  byte_t            s1_data_r;

  // block state
  byte_t mode_one_r, mode_one_nxt;
  byte_t mode_two_r, mode_two_nxt;
  byte_t pre_val_r,  pre_val_nxt;
  byte_t pre_cnt_r,  pre_cnt_nxt;
  cyc_t  cyc_r,      cyc_nxt;

  // result register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic        advance;
  logic        proc;
  logic        is_wr;
  logic        is_rd;
  logic        is_tick;
  logic        ch_hit;
  logic        all_hit;
  byte_t       ch_off;
  byte_t       all_off;
  byte_t       rd_data;
  scpwm_wr_t   lane_wr    [CHANNELS];
  chan_bytes_t lane_bytes [CHANNELS];
  logic [CHANNELS-1:0] lane_lvl;
  logic [PWM_W-1:0]    levels;

  // handshake
  assign advance   = !out_valid_r || out_tready;
  assign proc      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_act_r  <= in_tuser;
      s1_addr_r <= in_tdata[7:0];
      s1_data_r <= in_tdata[15:8];
    end
  end

  // operation decode
  assign is_wr   = proc && (s1_act_r == ACT_WRITE);
  assign is_rd   = proc && (s1_act_r == ACT_READ);
  assign is_tick = proc && (s1_act_r == ACT_TICK);
  assign ch_off  = s1_addr_r - CH_BASE;
  assign all_off = s1_addr_r - ALL_BASE;
  assign ch_hit  = (s1_addr_r >= CH_BASE) && (ch_off < BYTE_W'(CH_SPAN));
  assign all_hit = (s1_addr_r >= ALL_BASE) && (s1_addr_r <= ALL_LAST);

  // mode, prescale and counters
  always_comb begin
    mode_one_nxt = mode_one_r;
    mode_two_nxt = mode_two_r;
    pre_val_nxt  = pre_val_r;
    pre_cnt_nxt  = pre_cnt_r;
    cyc_nxt      = cyc_r;
    if (is_wr) begin
      if (s1_addr_r == ADDR_MODE1) begin
        mode_one_nxt = s1_data_r;
      end else if (s1_addr_r == ADDR_MODE2) begin
        mode_two_nxt = s1_data_r;
      end else if ((s1_addr_r == PRESCALE_ADDR) && mode_one_r[SLEEP_BIT]) begin
        pre_val_nxt = (s1_data_r < PRESCALE_FLOOR) ? PRESCALE_FLOOR : s1_data_r;
      end
    end
    if (is_tick && !mode_one_r[SLEEP_BIT]) begin
      if (pre_cnt_r >= pre_val_r) begin
        pre_cnt_nxt = '0;
        cyc_nxt     = cyc_r + cyc_t'(1);
      end else begin
        pre_cnt_nxt = pre_cnt_r + byte_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_one_r <= MODE1_RST;
      mode_two_r <= MODE2_RST;
      pre_val_r  <= PRESCALE_RST;
      pre_cnt_r  <= '0;
      cyc_r      <= '0;
    end else begin
      mode_one_r <= mode_one_nxt;
      mode_two_r <= mode_two_nxt;
      pre_val_r  <= pre_val_nxt;
      pre_cnt_r  <= pre_cnt_nxt;
      cyc_r      <= cyc_nxt;
    end
  end

  // channel lanes
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    always_comb begin
      lane_wr[g].en   = is_wr && (all_hit || (ch_hit && (ch_off[7:2] == 6'(g))));
      lane_wr[g].slot = all_hit ? all_off[1:0] : ch_off[1:0];
      lane_wr[g].data = s1_data_r;
    end

    scpwm_chan u_chan (
      .clk        (clk),
      .rst_n      (rst_n),
      .wr         (lane_wr[g]),
      .cyc_nxt    (cyc_nxt),
      .invert_nxt (mode_two_nxt[INVERT_BIT]),
      .bytes      (lane_bytes[g]),
      .level_nxt  (lane_lvl[g])
    );
  end

  // unused channel bits read as zero
  for (genvar g = 0; g < PWM_W; g++) begin : g_lvl
    if (g < CHANNELS) begin : g_used
      assign levels[g] = lane_lvl[g];
    end else begin : g_zero
      assign levels[g] = 1'b0;
    end
  end

  // read mux
  always_comb begin
    rd_data = '0;
    if (is_rd) begin
      if (s1_addr_r == ADDR_MODE1) begin
        rd_data = mode_one_r;
      end else if (s1_addr_r == ADDR_MODE2) begin
        rd_data = mode_two_r;
      end else if (s1_addr_r == PRESCALE_ADDR) begin
        rd_data = pre_val_r;
      end else if (ch_hit) begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (ch_off[7:2] == 6'(i)) begin
            rd_data = lane_bytes[i][ch_off[1:0]];
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_data_r <= {levels, rd_data};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== src/scpwm_chk.sv =====
// ----------------------------------------------------------------------------
// scpwm_chk
// port-level checks of the pwm register block, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scpwm_chk (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tvalid,
  input wire logic                                in_tready,
  input wire logic [scpwm_pkg::IN_DATA_W-1:0]     in_tdata,
  input wire logic [scpwm_pkg::ACT_W-1:0]         in_tuser,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [scpwm_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import scpwm_pkg::*;

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result payload changed while stalled");

  // input backpressure only comes from a stalled result
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a stalled result");

  // an accepted beat reaches the output through the input and result registers when the receiver keeps up
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready ##1 out_tready |=> out_tvalid)
    else $error("result beat missing after accepted input");

  // unmapped address reads back zero
  a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == ACT_READ) && (in_tdata[7:0] == 8'hFF)
    ##1 out_tready |=> (out_tdata[7:0] == 8'h00))
    else $error("read of unmapped address returned data");

endmodule

bind sixteen_channel_pwm_register_block scpwm_chk u_scpwm_chk (.*);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// stream-level test of the sixteen channel pwm register block: directed
// register and window cases, then random register traffic and ticks, with
// random idling on both sides and one long output hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import scpwm_pkg::*;

  // action code with no register effect
  localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    byte_t            rd;
    logic [PWM_W-1:0] levels;
  } pwm_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [ACT_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  sixteen_channel_pwm_register_block u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // shadow copy of the register file and counters
  byte_t pwm_chan_mem [CH_SPAN];
  byte_t pwm_mode1;
  byte_t pwm_mode2;
  byte_t pwm_presc_val;
  byte_t pwm_presc_cnt;
  cyc_t  pwm_cyc;

  pwm_result_t expected_results[$];
  pwm_result_t next_expected;
  int err_cnt = 0;
  int cycle_cnt = 0;
  bit src_idle_en = 1'b0;
  bit sink_idle_en = 1'b0;
  bit hold_req = 1'b0;
  int stall_left = 0;

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic reset_pwm_shadow();
    for (int i = 0; i < CH_SPAN; i++)
      pwm_chan_mem[i] = (i[1:0] == SLOT_OFF_H) ? OFF_H_RST : 8'h00;
    pwm_mode1     = MODE1_RST;
    pwm_mode2     = MODE2_RST;
    pwm_presc_val = PRESCALE_RST;
    pwm_presc_cnt = '0;
    pwm_cyc       = '0;
  endtask

  // level of one channel from its on/off window and override bits
  function automatic logic chan_level(int ch);
    byte_t on_h, off_h;
    cyc_t  on_v, off_v;
    logic  lvl;
    on_h  = pwm_chan_mem[ch*4 + SLOT_ON_H];
    off_h = pwm_chan_mem[ch*4 + SLOT_OFF_H];
    on_v  = {on_h[3:0], pwm_chan_mem[ch*4 + SLOT_ON_L]};
    off_v = {off_h[3:0], pwm_chan_mem[ch*4 + SLOT_OFF_L]};
    if (off_h[FORCE_BIT])
      lvl = 1'b0;
    else if (on_h[FORCE_BIT])
      lvl = 1'b1;
    else if (on_v < off_v)
      lvl = (pwm_cyc >= on_v) && (pwm_cyc < off_v);
    else if (on_v > off_v)
      lvl = (pwm_cyc >= on_v) || (pwm_cyc < off_v);
    else
      lvl = 1'b0;
    return lvl ^ pwm_mode2[INVERT_BIT];
  endfunction

  // apply one operation to the shadow state, return the result beat
  function automatic pwm_result_t apply_pwm_op(logic [ACT_W-1:0] kind, byte_t addr,
                                               byte_t wdata);
    pwm_result_t res;
    int k;
    res = '0;
    case (kind)
      ACT_WRITE: begin
        if (addr == ADDR_MODE1)
          pwm_mode1 = wdata;
        else if (addr == ADDR_MODE2)
          pwm_mode2 = wdata;
        else if (addr >= CH_BASE && addr < CH_BASE + CH_SPAN)
          pwm_chan_mem[addr - CH_BASE] = wdata;
        else if (addr >= ALL_BASE && addr <= ALL_LAST) begin
          k = addr - ALL_BASE;
          for (int ch = 0; ch < CHANNELS; ch++)
            pwm_chan_mem[ch*4 + k] = wdata;
        end else if (addr == PRESCALE_ADDR && pwm_mode1[SLEEP_BIT])
          pwm_presc_val = (wdata < PRESCALE_FLOOR) ? PRESCALE_FLOOR : wdata;
      end
      ACT_READ: begin
        if (addr == ADDR_MODE1)
          res.rd = pwm_mode1;
        else if (addr == ADDR_MODE2)
          res.rd = pwm_mode2;
        else if (addr >= CH_BASE && addr < CH_BASE + CH_SPAN)
          res.rd = pwm_chan_mem[addr - CH_BASE];
        else if (addr == PRESCALE_ADDR)
          res.rd = pwm_presc_val;
      end
      ACT_TICK: begin
        if (!pwm_mode1[SLEEP_BIT]) begin
          if (pwm_presc_cnt >= pwm_presc_val) begin
            pwm_presc_cnt = '0;
            pwm_cyc = pwm_cyc + 1'b1;
          end else begin
            pwm_presc_cnt = pwm_presc_cnt + 1'b1;
          end
        end
      end
      default: ;
    endcase
    for (int ch = 0; ch < CHANNELS; ch++)
      res.levels[ch] = chan_level(ch);
    return res;
  endfunction

  // send one beat, with an optional idle burst ahead of it
  task automatic push_op(input logic [ACT_W-1:0] kind, input byte_t addr, input byte_t wdata);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {wdata, addr};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(apply_pwm_op(kind, addr, wdata));
  endtask

  // receiver: random stall bursts, one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && sink_idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with none pending, actual %h", $time, out_tdata);
        err_cnt++;
      end else begin
        next_expected = expected_results.pop_front();
        if (out_tdata[7:0] !== next_expected.rd) begin
          $display("%0t: read_data expected %h actual %h", $time, next_expected.rd,
                   out_tdata[7:0]);
          err_cnt++;
        end
        if (out_tdata[23:8] !== next_expected.levels) begin
          $display("%0t: pwm_levels expected %h actual %h", $time, next_expected.levels,
                   out_tdata[23:8]);
          err_cnt++;
        end
      end
    end
  end

  // byte for a channel slot, placed near the running cycle count
  function automatic byte_t window_byte(logic [1:0] slot);
    byte_t b;
    if (slot == SLOT_ON_H || slot == SLOT_OFF_H) begin
      b = byte_t'($urandom_range(0, 255));
      b[FORCE_BIT] = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 7) != 0)
        b[3:0] = pwm_cyc[11:8];
    end else begin
      b = byte_t'(pwm_cyc[7:0] + $urandom_range(0, 48) - 8);
    end
    return b;
  endfunction

  // reset values, empty addresses, no-op action, tick while asleep
  task automatic test_reset_values();
    push_op(ACT_READ, ADDR_MODE1, 8'h00);
    push_op(ACT_READ, ADDR_MODE2, 8'h00);
    push_op(ACT_READ, PRESCALE_ADDR, 8'h00);
    push_op(ACT_READ, CH_BASE + SLOT_OFF_H, 8'h00);
    push_op(ACT_READ, 8'h02, 8'h00);
    push_op(ACT_READ, 8'hFF, 8'h00);
    push_op(ACT_NOP, 8'hFF, 8'hFF);
    push_op(ACT_TICK, 8'h00, 8'h00);
  endtask

  // prescale floor, write while awake dropped
  task automatic test_prescale_rules();
    push_op(ACT_WRITE, PRESCALE_ADDR, 8'h00);
    push_op(ACT_READ, PRESCALE_ADDR, 8'h00);
    push_op(ACT_WRITE, ADDR_MODE1, 8'h01);
    push_op(ACT_WRITE, PRESCALE_ADDR, 8'hFF);
    push_op(ACT_READ, PRESCALE_ADDR, 8'h00);
  endtask

  // window shapes, overrides, invert, all-channel and unmapped writes
  task automatic test_window_shapes();
    push_op(ACT_WRITE, ALL_BASE + SLOT_OFF_H, 8'h00);
    push_op(ACT_WRITE, ALL_BASE + SLOT_OFF_L, 8'h02);
    push_op(ACT_WRITE, CH_BASE + 8'd4 + SLOT_ON_H, 8'h10);
    push_op(ACT_WRITE, CH_BASE + 8'd8 + SLOT_ON_H, 8'h10);
    push_op(ACT_WRITE, CH_BASE + 8'd8 + SLOT_OFF_H, 8'h10);
    push_op(ACT_WRITE, CH_BASE + 8'd12 + SLOT_ON_L, 8'h05);
    push_op(ACT_WRITE, 8'h46, 8'hFF);
    push_op(ACT_READ, 8'h46, 8'h00);
    push_op(ACT_WRITE, ADDR_MODE2, 8'hFF);
    repeat (4) push_op(ACT_TICK, 8'h00, 8'h00);
    push_op(ACT_READ, ALL_BASE, 8'h00);
    push_op(ACT_WRITE, ADDR_MODE2, 8'h00);
  endtask

  // random register traffic and ticks
  task automatic test_random_traffic(input int n_ops);
    int pick;
    int sel;
    logic [1:0] slot;
    byte_t addr;
    byte_t val;
    for (int i = 0; i < n_ops; i++) begin
      pick = $urandom_range(0, 99);
      slot = 2'($urandom_range(0, 3));
      if (pick < 40) begin
        push_op(ACT_TICK, byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)));
      end else if (pick < 62) begin
        addr = byte_t'(CH_BASE + 4 * $urandom_range(0, CHANNELS - 1) + slot);
        push_op(ACT_WRITE, addr, window_byte(slot));
      end else if (pick < 77) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) addr = ADDR_MODE1;
        else if (sel == 1) addr = ADDR_MODE2;
        else if (sel == 2) addr = PRESCALE_ADDR;
        else if (sel < 7) addr = byte_t'(CH_BASE + $urandom_range(0, CH_SPAN - 1));
        else addr = byte_t'($urandom_range(0, 255));
        push_op(ACT_READ, addr, byte_t'($urandom_range(0, 255)));
      end else if (pick < 82) begin
        push_op(ACT_WRITE, ALL_BASE + slot, window_byte(slot));
      end else if (pick < 86) begin
        val = byte_t'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0)
          val[SLEEP_BIT] = 1'b0;
        push_op(ACT_WRITE, ADDR_MODE1, val);
      end else if (pick < 90) begin
        push_op(ACT_WRITE, ADDR_MODE2, byte_t'($urandom_range(0, 255)));
      end else if (pick < 94) begin
        // sleep, new prescale, wake
        val = byte_t'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) :
                                                     $urandom_range(0, 8));
        push_op(ACT_WRITE, ADDR_MODE1, pwm_mode1 | (8'h01 << SLEEP_BIT));
        push_op(ACT_WRITE, PRESCALE_ADDR, val);
        push_op(ACT_WRITE, ADDR_MODE1, pwm_mode1 & ~(8'h01 << SLEEP_BIT));
      end else begin
        push_op(ACT_W'($urandom_range(0, 3)), byte_t'($urandom_range(0, 255)),
                byte_t'($urandom_range(0, 255)));
      end
    end
  endtask

  // long output hold while beats keep coming
  task automatic test_output_backpressure();
    src_idle_en = 1'b0;
    hold_req = 1'b1;
    test_random_traffic(40);
  endtask

  initial begin
    reset_pwm_shadow();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_prescale_rules();
    test_window_shapes();
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    test_random_traffic(890);
    test_output_backpressure();
    // quiet tail, no idling
    sink_idle_en = 1'b0;
    test_random_traffic(30);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/scpwm_pkg.sv
src/scpwm_chan.sv
src/sixteen_channel_pwm_register_block.sv
src/scpwm_chk.sv
tb/sv/tb_top.sv
